[hw/rtl/lert_pkg.sv]
// Package for the lane edge row tracker: frame geometry, state types and the
// capture-side control struct. Depends on nothing.
package lert_pkg;

    localparam int IMG_H     = 60;
    localparam int IMG_W     = 80;
    localparam int SEED_ROWS = 10;
    localparam int MID_COL   = IMG_W / 2;
    localparam int ROW_W     = $clog2(IMG_H);
    localparam int COL_W     = 7;
    localparam int EDGE_W    = 7;
    localparam int RECIP_10  = 1639;
    localparam int RECIP_SH  = 14;

    localparam logic [ROW_W-1:0] LAST_ROW_IDX = ROW_W'(IMG_H - 1);
    localparam logic [COL_W-1:0] LAST_COL_IDX = COL_W'(IMG_W - 1);

    typedef enum logic [2:0] {
        CAP_RUN,
        CAP_MERGE_RD,
        CAP_MERGE_WR,
        CAP_START,
        CAP_HOLD
    } cap_state_t;

    typedef enum logic [3:0] {
        SR_IDLE,
        SR_ROW_RD,
        SR_ROW_CAP,
        SR_PRED,
        SR_SIDE,
        SR_MUL,
        SR_TRACK,
        SR_CENTER,
        SR_SIDE_END,
        SR_CHECK,
        SR_EMIT
    } srch_state_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [ROW_W-1:0] addr;
        logic [IMG_W-1:0] wdata;
        logic             start;
    } cap_t;

endpackage

[hw/rtl/lane_edge_row_tracker.sv]
// Lane edge row tracker top level: configuration registers, frame store and
// the capture and search units. Depends on lert_pkg, lert_ram, lert_capture,
// lert_search.
//
// Pixels stream in at one per cycle while the capture unit is ready, and are
// packed into 80-bit rows of the frame store. The transfer with tlast starts
// the edge search (a partial last row first gets a read-merge-write); no pixel
// is taken until the last row result has been transferred. Each row is read
// from the frame store, then (above the bottom ten rows) the five-row edge
// store read of the prediction follows; per side columns are tried in turn,
// after a prediction divide when tracking: up to 2*hw+1 window columns, then
// up to 40 columns of center search. The row is then checked and its result
// presented, which is then held until taken; between 12 and 58 rows are
// reported per frame.
module lane_edge_row_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel_black
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // row_index, left_edge, right_edge, left_found,
                                   // right_found, center_column, valid_rows
    output logic        m_tlast    // last_row
);
    import lert_pkg::*;

    localparam logic REG_HALF_WIN = 1'b0;
    localparam logic REG_LOST_LIM = 1'b1;

    logic [4:0]       hw_reg;
    logic [3:0]       lim_reg;
    cap_t             cap;
    logic             done;
    logic             srch_re;
    logic [ROW_W-1:0] srch_raddr;
    logic [IMG_W-1:0] frame_rdata;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg  <= 5'd8;
            lim_reg <= 4'd5;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HALF_WIN: hw_reg  <= pwdata[4:0];
                REG_LOST_LIM: lim_reg <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HALF_WIN: prdata = {27'b0, hw_reg};
            REG_LOST_LIM: prdata = {28'b0, lim_reg};
            default:      prdata = '0;
        endcase
    end

    lert_ram #(.WIDTH(IMG_W), .DEPTH(IMG_H)) u_frame_ram (
        .aclk  (aclk),
        .we    (cap.we),
        .waddr (cap.addr),
        .wdata (cap.wdata),
        .re    (cap.re || srch_re),
        .raddr (cap.re ? cap.addr : srch_raddr),
        .rdata (frame_rdata)
    );

    lert_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel_black (s_tdata[0]),
        .frame_end   (s_tlast),
        .search_done (done),
        .rd_data     (frame_rdata),
        .cap         (cap)
    );

    lert_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cap.start),
        .half_win    (hw_reg),
        .lost_lim    (lim_reg),
        .frame_re    (srch_re),
        .frame_raddr (srch_raddr),
        .frame_rdata (frame_rdata),
        .done        (done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );
endmodule

[hw/rtl/lert_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the frame store and the edge store.
module lert_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hw/rtl/lert_capture.sv]
// Frame capture: gathers pixels into a row buffer and writes whole rows to the
// frame store, merging a partial last row. Depends on lert_pkg.
module lert_capture (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        pixel_black,
    input  logic                        frame_end,
    input  logic                        search_done,
    input  logic [lert_pkg::IMG_W-1:0]  rd_data,
    output lert_pkg::cap_t              cap
);
    import lert_pkg::*;

    cap_state_t       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             full_reg, full_next;
    logic [IMG_W-1:0] buf_reg, buf_next, buf_ins, merged;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CAP_RUN;
            row_reg   <= '0;
            col_reg   <= '0;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_comb begin
        buf_ins          = buf_reg;
        buf_ins[col_reg] = pixel_black;
        for (int i = 0; i < IMG_W; i++) begin
            merged[i] = (COL_W'(i) <= col_reg) ? buf_reg[i] : rd_data[i];
        end
    end

    assign s_tready = (state_reg == CAP_RUN);

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        full_next  = full_reg;
        buf_next   = buf_reg;
        cap        = '0;
        cap.addr   = row_reg;
        case (state_reg)
            CAP_RUN: begin
                if (s_tvalid) begin
                    if (!full_reg) begin
                        buf_next = buf_ins;
                        if (col_reg == LAST_COL_IDX) begin
                            cap.we    = 1'b1;
                            cap.wdata = buf_ins;
                            col_next  = '0;
                            if (row_reg == LAST_ROW_IDX) begin
                                full_next = 1'b1;
                            end else begin
                                row_next = row_reg + 1'b1;
                            end
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    if (frame_end) begin
                        if (!full_reg && col_reg != LAST_COL_IDX) begin
                            col_next   = col_reg;
                            state_next = CAP_MERGE_RD;
                        end else begin
                            row_next   = '0;
                            col_next   = '0;
                            full_next  = 1'b0;
                            state_next = CAP_START;
                        end
                    end
                end
            end
            CAP_MERGE_RD: begin
                cap.re     = 1'b1;
                state_next = CAP_MERGE_WR;
            end
            CAP_MERGE_WR: begin
                cap.we     = 1'b1;
                cap.wdata  = merged;
                row_next   = '0;
                col_next   = '0;
                full_next  = 1'b0;
                state_next = CAP_START;
            end
            CAP_START: begin
                cap.start  = 1'b1;
                state_next = CAP_HOLD;
            end
            CAP_HOLD: begin
                if (search_done) begin
                    state_next = CAP_RUN;
                end
            end
            default: begin
                state_next = CAP_RUN;
            end
        endcase
    end
endmodule

[hw/rtl/lert_search.sv]
// Row search: walks the stored frame from the bottom row, finds both lane
// edges per row, keeps the edge store and emits one result per row.
// Depends on lert_pkg and lert_ram.
module lert_search (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [4:0]                  half_win,
    input  logic [3:0]                  lost_lim,
    output logic                        frame_re,
    output logic [lert_pkg::ROW_W-1:0]  frame_raddr,
    input  logic [lert_pkg::IMG_W-1:0]  frame_rdata,
    output logic                        done,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // row_index, left_edge, right_edge,
                                                   // left_found, right_found,
                                                   // center_column, valid_rows
    output logic                        m_tlast    // last_row
);
    import lert_pkg::*;

    localparam int ACC_W  = 12;
    localparam int ABS_W  = 11;
    localparam int PROD_W = 22;

    srch_state_t             state_reg, state_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [IMG_W-1:0]        pix_reg, pix_next;
    logic                    side_reg, side_next;
    logic [2:0]              pk_reg, pk_next;
    logic signed [ACC_W-1:0] accl_reg, accl_next, accr_reg, accr_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic signed [8:0]       cand_reg, cand_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic                    f_reg, f_next;
    logic [EDGE_W-1:0]       e_reg, e_next;
    logic [EDGE_W-1:0]       l_reg, l_next, r_reg, r_next;
    logic                    lf_reg, lf_next, rf_reg, rf_next;
    logic [7:0]              lostl_reg, lostl_next, foundl_reg, foundl_next;
    logic [7:0]              lostr_reg, lostr_next, foundr_reg, foundr_next;
    logic [1:0]              bad_reg, bad_next;
    logic [5:0]              valid_reg, valid_next;
    logic                    mv_reg, mv_next;
    logic [39:0]             md_reg, md_next;
    logic                    ml_reg, ml_next;

    logic                    edge_we, edge_re;
    logic [ROW_W-1:0]        edge_raddr;
    logic [2*EDGE_W-1:0]     edge_rdata;

    lert_ram #(.WIDTH(2 * EDGE_W), .DEPTH(IMG_H)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (row_reg),
        .wdata ({r_reg, l_reg}),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    function automatic logic px(input logic [IMG_W-1:0] r, input logic signed [8:0] c);
        logic v;
        v = 1'b0;
        if (c >= 0 && c < IMG_W) begin
            v = r[c[COL_W-1:0]];
        end
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] coef_term(input logic [2:0] k,
                                                          input logic [EDGE_W-1:0] y);
        logic signed [ACC_W-1:0] ys, t;
        ys = ACC_W'(y);
        case (k)
            3'd0:    t = ys <<< 3;
            3'd1:    t = (ys <<< 2) + ys;
            3'd2:    t = ys <<< 1;
            3'd3:    t = -ys;
            3'd4:    t = -(ys <<< 2);
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    logic                    seed, track, cur_match, center_bad;
    logic signed [ACC_W-1:0] acc_sel;
    logic [ABS_W-1:0]        acc_abs;
    logic [7:0]              q;
    logic signed [8:0]       pred, cc, hw_s;
    logic [7:0]              lost_cur, found_cur, nl, nf;
    logic [EDGE_W-1:0]       e_fin;
    logic [7:0]              sum_lr;
    logic signed [7:0]       diff_lr;
    logic [COL_W-1:0]        ctr_col;
    logic [1:0]              bad_new;
    logic                    ended, is_last;
    logic [5:0]              valid_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SR_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        pix_reg    <= pix_next;
        side_reg   <= side_next;
        pk_reg     <= pk_next;
        accl_reg   <= accl_next;
        accr_reg   <= accr_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        cand_reg   <= cand_next;
        cnt_reg    <= cnt_next;
        f_reg      <= f_next;
        e_reg      <= e_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        lf_reg     <= lf_next;
        rf_reg     <= rf_next;
        lostl_reg  <= lostl_next;
        foundl_reg <= foundl_next;
        lostr_reg  <= lostr_next;
        foundr_reg <= foundr_next;
        bad_reg    <= bad_next;
        valid_reg  <= valid_next;
        md_reg     <= md_next;
        ml_reg     <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    always_comb begin
        seed      = (row_reg >= ROW_W'(IMG_H - SEED_ROWS));
        lost_cur  = side_reg ? lostr_reg : lostl_reg;
        found_cur = side_reg ? foundr_reg : foundl_reg;
        track     = !seed && (lost_cur < 8'(lost_lim)) && (found_cur >= 8'(lost_lim));
        acc_sel   = side_reg ? accr_reg : accl_reg;
        acc_abs   = acc_sel[ACC_W-1] ? ABS_W'(-acc_sel) : ABS_W'(acc_sel);
        q         = prod_reg[PROD_W-1:RECIP_SH];
        pred      = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        hw_s      = $signed({4'b0, half_win});
        if (state_reg == SR_TRACK) begin
            cc = cand_reg;
        end else if (side_reg) begin
            cc = 9'(MID_COL) + $signed({2'b0, cnt_reg});
        end else begin
            cc = 9'(MID_COL) - $signed({2'b0, cnt_reg});
        end
        if (side_reg) begin
            cur_match = px(pix_reg, cc) && !px(pix_reg, cc - 9'sd1)
                        && !px(pix_reg, cc - 9'sd2) && !px(pix_reg, cc - 9'sd3);
        end else if (state_reg == SR_TRACK) begin
            cur_match = px(pix_reg, cc) && !px(pix_reg, cc + 9'sd1)
                        && !px(pix_reg, cc + 9'sd2) && !px(pix_reg, cc + 9'sd3);
        end else begin
            cur_match = px(pix_reg, cc - 9'sd1) && !px(pix_reg, cc)
                        && !px(pix_reg, cc + 9'sd1) && !px(pix_reg, cc + 9'sd2);
        end
        if (seed) begin
            nf = found_cur;
            nl = f_reg ? lost_cur : sat_inc(lost_cur);
        end else if (f_reg) begin
            nf = sat_inc(found_cur);
            nl = '0;
        end else begin
            nl = sat_inc(lost_cur);
            nf = (nl >= 8'(lost_lim)) ? 8'd0 : found_cur;
        end
        e_fin      = f_reg ? e_reg : (side_reg ? EDGE_W'(IMG_W - 1) : '0);
        sum_lr     = {1'b0, l_reg} + {1'b0, r_reg};
        ctr_col    = sum_lr[7:1];
        diff_lr    = $signed({1'b0, l_reg}) - $signed({1'b0, r_reg});
        center_bad = pix_reg[ctr_col] || (diff_lr > 8'sd1);
        if (center_bad) begin
            bad_new = (bad_reg == 2'd3) ? bad_reg : bad_reg + 2'd1;
        end else begin
            bad_new = '0;
        end
        ended     = !seed && (bad_new >= 2'd2);
        is_last   = !seed && (ended || row_reg == ROW_W'(2));
        valid_new = ended ? valid_reg : valid_reg + 6'd1;
    end

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        pix_next    = pix_reg;
        side_next   = side_reg;
        pk_next     = pk_reg;
        accl_next   = accl_reg;
        accr_next   = accr_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        cand_next   = cand_reg;
        cnt_next    = cnt_reg;
        f_next      = f_reg;
        e_next      = e_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        lf_next     = lf_reg;
        rf_next     = rf_reg;
        lostl_next  = lostl_reg;
        foundl_next = foundl_reg;
        lostr_next  = lostr_reg;
        foundr_next = foundr_reg;
        bad_next    = bad_reg;
        valid_next  = valid_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        ml_next     = ml_reg;
        frame_re    = 1'b0;
        frame_raddr = row_reg;
        edge_we     = 1'b0;
        edge_re     = 1'b0;
        edge_raddr  = row_reg + ROW_W'(pk_reg) + ROW_W'(1);
        done        = 1'b0;
        case (state_reg)
            SR_IDLE: begin
                if (start) begin
                    row_next    = LAST_ROW_IDX;
                    lostl_next  = '0;
                    foundl_next = '0;
                    lostr_next  = '0;
                    foundr_next = '0;
                    bad_next    = '0;
                    valid_next  = '0;
                    state_next  = SR_ROW_RD;
                end
            end
            SR_ROW_RD: begin
                frame_re   = 1'b1;
                state_next = SR_ROW_CAP;
            end
            SR_ROW_CAP: begin
                pix_next  = frame_rdata;
                pk_next   = '0;
                accl_next = ACC_W'(5);
                accr_next = ACC_W'(5);
                side_next = 1'b0;
                state_next = seed ? SR_SIDE : SR_PRED;
            end
            SR_PRED: begin
                edge_re = (pk_reg < 3'd5);
                if (pk_reg != '0) begin
                    accl_next = accl_reg + coef_term(pk_reg - 3'd1, edge_rdata[EDGE_W-1:0]);
                    accr_next = accr_reg + coef_term(pk_reg - 3'd1,
                                                     edge_rdata[2*EDGE_W-1:EDGE_W]);
                end
                pk_next = pk_reg + 3'd1;
                if (pk_reg == 3'd5) begin
                    state_next = SR_SIDE;
                end
            end
            SR_SIDE: begin
                cnt_next = '0;
                f_next   = 1'b0;
                if (track) begin
                    neg_next   = acc_sel[ACC_W-1];
                    prod_next  = PROD_W'(acc_abs) * PROD_W'(RECIP_10);
                    state_next = SR_MUL;
                end else begin
                    state_next = SR_CENTER;
                end
            end
            SR_MUL: begin
                cand_next  = side_reg ? pred - hw_s : pred + hw_s;
                state_next = SR_TRACK;
            end
            SR_TRACK: begin
                cnt_next  = cnt_reg + 7'd1;
                cand_next = side_reg ? cand_reg + 9'sd1 : cand_reg - 9'sd1;
                if (!side_reg && cand_reg > 9'(IMG_W - 8)) begin
                    if (cnt_reg == {1'b0, half_win, 1'b0}) begin
                        cnt_next   = '0;
                        state_next = SR_CENTER;
                    end
                end else if (side_reg && cand_reg < 9'sd7) begin
                    if (cnt_reg == {1'b0, half_win, 1'b0}) begin
                        cnt_next   = '0;
                        state_next = SR_CENTER;
                    end
                end else if ((!side_reg && cand_reg < 0) ||
                             (side_reg && cand_reg > 9'(IMG_W - 1))) begin
                    cnt_next   = '0;
                    state_next = SR_CENTER;
                end else if (cur_match) begin
                    f_next     = 1'b1;
                    e_next     = side_reg ? EDGE_W'(cand_reg - 9'sd1)
                                          : EDGE_W'(cand_reg + 9'sd1);
                    state_next = SR_SIDE_END;
                end else if (cnt_reg == {1'b0, half_win, 1'b0}) begin
                    cnt_next   = '0;
                    state_next = SR_CENTER;
                end
            end
            SR_CENTER: begin
                cnt_next = cnt_reg + 7'd1;
                if (cur_match) begin
                    f_next     = 1'b1;
                    e_next     = side_reg ? EDGE_W'(cc - 9'sd1) : EDGE_W'(cc);
                    state_next = SR_SIDE_END;
                end else if (cnt_reg == 7'(MID_COL - 1)) begin
                    state_next = SR_SIDE_END;
                end
            end
            SR_SIDE_END: begin
                if (side_reg) begin
                    lostr_next  = nl;
                    foundr_next = nf;
                    r_next      = e_fin;
                    rf_next     = f_reg;
                    state_next  = SR_CHECK;
                end else begin
                    lostl_next  = nl;
                    foundl_next = nf;
                    l_next      = e_fin;
                    lf_next     = f_reg;
                    side_next   = 1'b1;
                    state_next  = SR_SIDE;
                end
            end
            SR_CHECK: begin
                edge_we = 1'b1;
                if (!seed) begin
                    bad_next = bad_new;
                end
                valid_next = valid_new;
                mv_next    = 1'b1;
                ml_next    = is_last;
                md_next    = {5'b0, valid_new, ctr_col, rf_reg, lf_reg, r_reg, l_reg, row_reg};
                state_next = SR_EMIT;
            end
            SR_EMIT: begin
                if (m_tready) begin
                    mv_next = 1'b0;
                    if (ml_reg) begin
                        done       = 1'b1;
                        state_next = SR_IDLE;
                    end else begin
                        row_next   = row_reg - ROW_W'(1);
                        state_next = SR_ROW_RD;
                    end
                end
            end
            default: begin
                state_next = SR_IDLE;
            end
        endcase
    end
endmodule

[verif/tb.sv]
// Testbench for lane_edge_row_tracker: streams binary frames, predicts the row
// results in SystemVerilog and checks every result transfer. Depends on lert_pkg.
module tb;
    import lert_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_PIX = IMG_H * IMG_W;
    localparam int IDLE_LIMIT = 40000;
    localparam logic [2:0] ADDR_HALF_WIN = 3'd0;
    localparam logic [2:0] ADDR_LOST_LIM = 3'd4;

    typedef struct {
        bit px;
        bit fe;
    } pixel_t;

    typedef struct {
        logic [5:0] row;
        logic [6:0] ledge;
        logic [6:0] redge;
        logic       lf;
        logic       rf;
        logic [6:0] center;
        logic [5:0] vrows;
        logic       last;
    } row_res_t;

    logic        aclk, aresetn;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [39:0] m_tdata;

    lane_edge_row_tracker dut (.*);

    // predictor state
    bit       frame_mem [FRAME_PIX];
    int       wr_pos;
    int       edges [2][IMG_H];
    int       lost_run [2], found_run [2];
    int       half_win, lost_lim;

    pixel_t   pend_q [$];
    row_res_t rows_q [$];
    pixel_t   cur;
    int       in_gap, out_gap, hold_cnt, stall_pct, gap_pct;
    bit       hold_req;
    int       fails, mism, idle_cnt;
    bit       img [FRAME_PIX];

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pix(int r, int c);
        if (r < 0 || r >= IMG_H || c < 0 || c >= IMG_W) return 0;
        return frame_mem[r*IMG_W + c];
    endfunction

    function automatic int scan_center(int r, int side);
        int c;
        for (int t = 0; t < MID_COL; t++) begin
            if (side == 0) begin
                c = MID_COL - t;
                if (pix(r, c-1) && !pix(r, c) && !pix(r, c+1) && !pix(r, c+2)) return c;
            end else begin
                c = MID_COL + t;
                if (pix(r, c) && !pix(r, c-1) && !pix(r, c-2) && !pix(r, c-3))
                    return c - 1;
            end
        end
        return -1;
    endfunction

    function automatic int fit_edge(int side, int r);
        int y1, y2, y3, y4, y5, s, n;
        y1 = edges[side][r+1]; y2 = edges[side][r+2]; y3 = edges[side][r+3];
        y4 = edges[side][r+4]; y5 = edges[side][r+5];
        s = -2*y1 - y2 + y4 + 2*y5;
        n = 2*(y1+y2+y3+y4+y5) - 3*s + 5;
        return n / 10;
    endfunction

    function automatic int scan_window(int r, int side);
        int p, c;
        p = fit_edge(side, r);
        for (int t = 0; t < 2*half_win + 1; t++) begin
            if (side == 0) begin
                c = p - t + half_win;
                if (c + 7 > IMG_W - 1) continue;
                if (c < 0) break;
                if (pix(r, c) && !pix(r, c+1) && !pix(r, c+2) && !pix(r, c+3)) return c + 1;
            end else begin
                c = p + t - half_win;
                if (c - 7 < 0) continue;
                if (c > IMG_W - 1) break;
                if (pix(r, c) && !pix(r, c-1) && !pix(r, c-2) && !pix(r, c-3)) return c - 1;
            end
        end
        return -1;
    endfunction

    function automatic int locate_edge(int r, int side);
        int e;
        if (lost_run[side] >= lost_lim || found_run[side] < lost_lim) begin
            e = scan_center(r, side);
        end else begin
            e = scan_window(r, side);
            if (e < 0) e = scan_center(r, side);
        end
        if (e >= 0) begin
            if (found_run[side] < 255) found_run[side]++;
            lost_run[side] = 0;
        end else begin
            if (lost_run[side] < 255) lost_run[side]++;
            if (lost_run[side] >= lost_lim) found_run[side] = 0;
        end
        return e;
    endfunction

    function automatic row_res_t make_row(int r, int lf, int rf, int v);
        row_res_t x;
        x.row = r; x.ledge = edges[0][r]; x.redge = edges[1][r];
        x.lf = lf; x.rf = rf;
        x.center = (edges[0][r] + edges[1][r]) / 2;
        x.vrows = v; x.last = 0;
        return x;
    endfunction

    task automatic trace_frame();
        row_res_t res [$];
        row_res_t x;
        int v, l, rr, lc, rc, bad;
        bit ended;
        v = 0; bad = 0; ended = 0;
        for (int s = 0; s < 2; s++) begin
            lost_run[s] = 0; found_run[s] = 0;
        end
        for (int i = 0; i < IMG_H; i++) begin
            edges[0][i] = 0; edges[1][i] = IMG_W - 1;
        end
        for (int r = IMG_H - 1; r > IMG_H - 1 - SEED_ROWS; r--) begin
            l = scan_center(r, 0); rr = scan_center(r, 1);
            if (l >= 0) edges[0][r] = l;
            else if (lost_run[0] < 255) lost_run[0]++;
            if (rr >= 0) edges[1][r] = rr;
            else if (lost_run[1] < 255) lost_run[1]++;
            v++;
            res.push_back(make_row(r, l >= 0, rr >= 0, v));
        end
        for (int r = IMG_H - 1 - SEED_ROWS; r >= 2 && !ended; r--) begin
            l = locate_edge(r, 0);
            edges[0][r] = (l >= 0) ? l : 0;
            rr = locate_edge(r, 1);
            edges[1][r] = (rr >= 0) ? rr : IMG_W - 1;
            lc = edges[0][r]; rc = edges[1][r];
            if (pix(r, (lc + rc) / 2) || lc - rc > 1) begin
                if (bad < 3) bad++;
                if (bad >= 2) ended = 1;
            end else begin
                bad = 0;
            end
            if (!ended) v++;
            res.push_back(make_row(r, l >= 0, rr >= 0, v));
        end
        foreach (res[i]) begin
            x = res[i];
            x.last = (i == res.size() - 1);
            rows_q.push_back(x);
        end
    endtask

    task automatic take_pixel(pixel_t p);
        if (wr_pos < FRAME_PIX) begin
            frame_mem[wr_pos] = p.px;
            wr_pos++;
        end
        if (p.fe) begin
            trace_frame();
            wr_pos = 0;
        end
    endtask

    function automatic int pick_gap();
        int d;
        d = $urandom_range(0, 99);
        if (d >= gap_pct) return 0;
        if (d < 3) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0; s_tdata <= 0; s_tlast <= 0;
        end else begin
            if (s_tvalid && s_tready) take_pixel(cur);
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 0;
                end else if (pend_q.size() > 0) begin
                    cur = pend_q.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {7'b0, cur.px};
                    s_tlast <= cur.fe;
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_req && m_tvalid) begin
            hold_req = 0;
            hold_cnt = 800;
            m_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_tready <= 0;
        end else begin
            out_gap = ($urandom_range(0, 99) < stall_pct) ? pick_gap() : 0;
            m_tready <= (out_gap == 0);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        row_res_t e;
        row_res_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.row = m_tdata[5:0]; a.ledge = m_tdata[12:6]; a.redge = m_tdata[19:13];
            a.lf = m_tdata[20]; a.rf = m_tdata[21]; a.center = m_tdata[28:22];
            a.vrows = m_tdata[34:29]; a.last = m_tlast;
            if (rows_q.size() == 0) begin
                fails++;
                if (mism++ < 10) $display("unexpected row result, row %0d", a.row);
            end else begin
                e = rows_q.pop_front();
                if (a.row !== e.row || a.ledge !== e.ledge || a.redge !== e.redge ||
                    a.lf !== e.lf || a.rf !== e.rf || a.center !== e.center ||
                    a.vrows !== e.vrows || a.last !== e.last || m_tdata[39:35] !== 0) begin
                    fails++;
                    if (mism++ < 10)
                        $display("mismatch exp row %0d l %0d r %0d lf %0d rf %0d c %0d v %0d last %0d / got row %0d l %0d r %0d lf %0d rf %0d c %0d v %0d last %0d",
                            e.row, e.ledge, e.redge, e.lf, e.rf, e.center, e.vrows, e.last,
                            a.row, a.ledge, a.redge, a.lf, a.rf, a.center, a.vrows, a.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, int val);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_HALF_WIN) half_win = val & 5'h1f;
        else lost_lim = val & 4'hf;
    endtask

    task automatic push_img(int n);
        pixel_t p;
        for (int i = 0; i < n; i++) begin
            p.px = img[i % FRAME_PIX];
            p.fe = (i == n - 1);
            pend_q.push_back(p);
        end
    endtask

    task automatic fill_img(bit v);
        foreach (img[i]) img[i] = v;
    endtask

    task automatic draw_lanes(int noise_pct, int drop_pct, int stop_row);
        int lc, rc, sl, sr, w, d, L, R;
        lc = $urandom_range(5, 35); rc = $urandom_range(44, 76);
        sl = $urandom_range(0, 8) - 4; sr = $urandom_range(0, 8) - 4;
        w = $urandom_range(1, 3);
        fill_img(0);
        for (int r = 0; r < IMG_H; r++) begin
            d = IMG_H - 1 - r;
            L = lc + sl * d / 4 + int'($urandom_range(0, 2)) - 1;
            R = rc + sr * d / 4 + int'($urandom_range(0, 2)) - 1;
            for (int c = 0; c < IMG_W; c++) begin
                if ($urandom_range(0, 99) >= drop_pct &&
                    ((c <= L && c > L - w) || (c >= R && c < R + w)))
                    img[r*IMG_W + c] = 1;
                if ($urandom_range(0, 999) < noise_pct * 10) img[r*IMG_W + c] = 1;
                if (r < stop_row && c >= 30 && c <= 50) img[r*IMG_W + c] = 1;
            end
        end
    endtask

    task automatic wait_idle();
        wait (pend_q.size() == 0 && !s_tvalid && rows_q.size() == 0);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        int hw_vals [6];
        int ll_vals [6];
        hw_vals = '{8, 1, 16, 0, 31, 4};
        ll_vals = '{5, 1, 15, 0, 3, 2};
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; s_tlast = 0; m_tready = 0;
        wr_pos = 0; half_win = 8; lost_lim = 5; hold_req = 0; hold_cnt = 0;
        in_gap = 0; out_gap = 0; stall_pct = 30; gap_pct = 30;
        fails = 0; mism = 0; idle_cnt = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed frames
        reg_write(ADDR_HALF_WIN, 8);
        reg_write(ADDR_LOST_LIM, 5);
        draw_lanes(0, 0, 0);
        push_img(FRAME_PIX);
        wait_idle();
        fill_img(0);
        push_img(FRAME_PIX);
        wait_idle();
        fill_img(1);
        push_img(FRAME_PIX);
        wait_idle();
        push_img(1);
        wait_idle();
        draw_lanes(2, 10, 15);
        push_img(FRAME_PIX + 20);
        wait_idle();

        // random frames across register settings
        for (int f = 0; f < 14; f++) begin
            if (f % 2 == 0) begin
                reg_write(ADDR_HALF_WIN, (f / 2 < 6) ? hw_vals[f/2] : $urandom_range(0, 31));
                reg_write(ADDR_LOST_LIM, (f / 2 < 6) ? ll_vals[f/2] : $urandom_range(0, 15));
            end
            gap_pct = (f % 4 == 3) ? 0 : 30;
            stall_pct = (f % 4 == 3) ? 0 : 30;
            if (f == 5) hold_req = 1;
            if ($urandom_range(0, 5) == 0) begin
                fill_img($urandom_range(0, 1));
                push_img($urandom_range(1, 300));
            end else begin
                draw_lanes($urandom_range(0, 4), $urandom_range(0, 40),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(3, 45) : 0);
                push_img(FRAME_PIX);
            end
            // next frame queued right behind, so the input stalls during the hold
            if (f == 5) push_img(FRAME_PIX);
            wait_idle();
        end

        repeat (200) @(posedge aclk);
        if (fails == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/lert_pkg.sv
hw/rtl/lert_ram.sv
hw/rtl/lert_capture.sv
hw/rtl/lert_search.sv
hw/rtl/lane_edge_row_tracker.sv
verif/tb.sv
